[rtl/lmcs_pkg.sv]
// Shared types, constants and the control program of the LED matrix cursor scan unit.
`timescale 1ns / 1ps
`default_nettype none
package lmcs_pkg;

	localparam int MATRIX_SIZE  = 8;
	localparam int IDX_W        = $clog2(MATRIX_SIZE);
	localparam int EDGE         = MATRIX_SIZE - 1;
	localparam int ROW_IDX_MASK = 31 % MATRIX_SIZE;
	localparam int NUM_BTN      = 4;
	localparam int BTN_W        = 2;
	localparam int STEP_W       = 3;
	localparam int S_TDATA_W    = 8;
	localparam int M_TDATA_W    = 24;
	localparam int ROW_INDEX_W  = 3;
	localparam int FIELD_W      = 8;

	localparam logic [BTN_W-1:0] BTN_LEFT  = 2'd0;
	localparam logic [BTN_W-1:0] BTN_UP    = 2'd1;
	localparam logic [BTN_W-1:0] BTN_DOWN  = 2'd2;
	localparam logic [BTN_W-1:0] BTN_RIGHT = 2'd3;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_FETCH    = 3'd0;
	localparam step_t ST_DISPATCH = 3'd1;
	localparam step_t ST_CHECK    = 3'd2;
	localparam step_t ST_NEXT     = 3'd3;
	localparam step_t ST_MOVE     = 3'd4;
	localparam step_t ST_SET      = 3'd5;
	localparam step_t ST_EMIT     = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_CHECK,
		OP_MOVE,
		OP_SET,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_IS_SCAN,
		C_PRESS,
		C_BTN_MORE,
		C_EMIT_LAST
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target_t;
		step_t target_f;
	} uword_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic is_scan;
		logic press;
		logic btn_more;
		logic emit_last;
	} status_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			ST_FETCH:    w = '{OP_ACCEPT, C_IN_VALID,  ST_DISPATCH, ST_FETCH};
			ST_DISPATCH: w = '{OP_NOP,    C_IS_SCAN,   ST_EMIT,     ST_CHECK};
			ST_CHECK:    w = '{OP_CHECK,  C_PRESS,     ST_MOVE,     ST_NEXT};
			ST_NEXT:     w = '{OP_NOP,    C_BTN_MORE,  ST_CHECK,    ST_FETCH};
			ST_MOVE:     w = '{OP_MOVE,   C_ALWAYS,    ST_SET,      ST_SET};
			ST_SET:      w = '{OP_SET,    C_ALWAYS,    ST_FETCH,    ST_FETCH};
			ST_EMIT:     w = '{OP_EMIT,   C_EMIT_LAST, ST_FETCH,    ST_EMIT};
			default:     w = '{OP_NOP,    C_ALWAYS,    ST_FETCH,    ST_FETCH};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[rtl/lmcs_seq.sv]
// Step counter, control store and conditional branch logic.
`timescale 1ns / 1ps
`default_nettype none
module lmcs_seq (
	input  wire               clk,
	input  wire               arst_n,
	input  lmcs_pkg::status_t status,
	output lmcs_pkg::ctrl_t   ctrl
);

	lmcs_pkg::step_t  step_q;
	lmcs_pkg::step_t  step_next;
	lmcs_pkg::uword_t word;
	logic             cond_ok;

	always_comb begin
		word = lmcs_pkg::ucode(step_q);
		unique case (word.cond)
			lmcs_pkg::C_ALWAYS:    cond_ok = 1'b1;
			lmcs_pkg::C_IN_VALID:  cond_ok = status.in_valid;
			lmcs_pkg::C_IS_SCAN:   cond_ok = status.is_scan;
			lmcs_pkg::C_PRESS:     cond_ok = status.press;
			lmcs_pkg::C_BTN_MORE:  cond_ok = status.btn_more;
			lmcs_pkg::C_EMIT_LAST: cond_ok = status.emit_last;
			default:               cond_ok = 1'b1;
		endcase
		step_next = cond_ok ? word.target_t : word.target_f;
		ctrl.op   = word.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lmcs_pkg::ST_FETCH;
		end else begin
			step_q <= step_next;
		end
	end

endmodule
`default_nettype wire

[rtl/lmcs_dp.sv]
// Datapath: input latch, button levels, cursor, frame buffer and output register.
`timescale 1ns / 1ps
`default_nettype none
module lmcs_dp (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  lmcs_pkg::ctrl_t                        ctrl,
	output lmcs_pkg::status_t                      status,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	input  wire  [lmcs_pkg::S_TDATA_W-1:0]         s_tdata,
	input  wire                                    s_tuser,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	output logic [lmcs_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic                                   m_tlast
);

	localparam int PAD_W = lmcs_pkg::M_TDATA_W - lmcs_pkg::ROW_INDEX_W - 2 * lmcs_pkg::FIELD_W;

	logic                                action_q;
	logic [lmcs_pkg::NUM_BTN-1:0]        first_q;
	logic [lmcs_pkg::NUM_BTN-1:0]        confirm_q;
	logic [lmcs_pkg::NUM_BTN-1:0]        btn_q;
	logic [lmcs_pkg::BTN_W-1:0]          btn_cnt_q;
	logic [lmcs_pkg::IDX_W-1:0]          row_cnt_q;
	logic [lmcs_pkg::IDX_W-1:0]          cur_row_q;
	logic [lmcs_pkg::IDX_W-1:0]          cur_col_q;
	logic [lmcs_pkg::MATRIX_SIZE-1:0]    frame_q [lmcs_pkg::MATRIX_SIZE];

	logic                                out_valid_q;
	logic [lmcs_pkg::ROW_INDEX_W-1:0]    out_idx_q;
	logic [lmcs_pkg::FIELD_W-1:0]        out_sel_q;
	logic [lmcs_pkg::FIELD_W-1:0]        out_col_q;
	logic                                out_last_q;

	logic                                accept;
	logic                                prev_lvl;
	logic                                changed;
	logic                                press;
	logic                                out_free;
	logic                                emit_fire;
	logic                                row_is_last;
	logic [lmcs_pkg::IDX_W-1:0]          set_row;

	always_comb begin
		s_tready    = (ctrl.op == lmcs_pkg::OP_ACCEPT);
		accept      = s_tready && s_tvalid;
		prev_lvl    = btn_q[btn_cnt_q];
		changed     = (first_q[btn_cnt_q] != prev_lvl) && (confirm_q[btn_cnt_q] != prev_lvl);
		press       = changed && !confirm_q[btn_cnt_q];
		out_free    = !out_valid_q || m_tready;
		emit_fire   = (ctrl.op == lmcs_pkg::OP_EMIT) && out_free;
		row_is_last = (row_cnt_q == lmcs_pkg::IDX_W'(lmcs_pkg::EDGE));
		set_row     = cur_row_q & lmcs_pkg::IDX_W'(lmcs_pkg::ROW_IDX_MASK);

		status.in_valid  = s_tvalid;
		status.is_scan   = action_q;
		status.press     = press;
		status.btn_more  = (btn_cnt_q != '0);
		status.emit_last = emit_fire && row_is_last;

		m_tvalid = out_valid_q;
		m_tdata  = {{PAD_W{1'b0}}, out_col_q, out_sel_q, out_idx_q};
		m_tlast  = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q  <= 1'b0;
			first_q   <= '1;
			confirm_q <= '1;
			btn_q     <= '1;
			btn_cnt_q <= '0;
			row_cnt_q <= '0;
			cur_row_q <= '0;
			cur_col_q <= lmcs_pkg::IDX_W'(lmcs_pkg::EDGE);
			frame_q[0] <= {1'b1, {(lmcs_pkg::MATRIX_SIZE-1){1'b0}}};
			for (int i = 1; i < lmcs_pkg::MATRIX_SIZE; i++) begin
				frame_q[i] <= '0;
			end
		end else begin
			case (ctrl.op)
				lmcs_pkg::OP_ACCEPT: begin
					btn_cnt_q <= '0;
					row_cnt_q <= '0;
					if (accept) begin
						action_q  <= s_tuser;
						first_q   <= s_tdata[lmcs_pkg::NUM_BTN-1:0];
						confirm_q <= s_tdata[2*lmcs_pkg::NUM_BTN-1:lmcs_pkg::NUM_BTN];
					end
				end
				lmcs_pkg::OP_CHECK: begin
					if (changed) begin
						btn_q[btn_cnt_q] <= confirm_q[btn_cnt_q];
					end
					if (!press) begin
						btn_cnt_q <= btn_cnt_q + 1'b1;
					end
				end
				lmcs_pkg::OP_MOVE: begin
					case (btn_cnt_q)
						lmcs_pkg::BTN_LEFT: begin
							if (cur_col_q < lmcs_pkg::IDX_W'(lmcs_pkg::EDGE)) begin
								cur_col_q <= cur_col_q + 1'b1;
							end
						end
						lmcs_pkg::BTN_UP: begin
							if (cur_row_q != '0) begin
								cur_row_q <= cur_row_q - 1'b1;
							end
						end
						lmcs_pkg::BTN_DOWN: begin
							if (cur_row_q < lmcs_pkg::IDX_W'(lmcs_pkg::EDGE)) begin
								cur_row_q <= cur_row_q + 1'b1;
							end
						end
						default: begin
							if (cur_col_q != '0) begin
								cur_col_q <= cur_col_q - 1'b1;
							end
						end
					endcase
				end
				lmcs_pkg::OP_SET: begin
					frame_q[set_row][cur_col_q] <= 1'b1;
				end
				lmcs_pkg::OP_EMIT: begin
					if (emit_fire) begin
						row_cnt_q <= row_cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_idx_q  <= lmcs_pkg::ROW_INDEX_W'(row_cnt_q);
			out_sel_q  <= lmcs_pkg::FIELD_W'(1) << row_cnt_q;
			out_col_q  <= lmcs_pkg::FIELD_W'(frame_q[row_cnt_q]);
			out_last_q <= row_is_last;
		end
	end

endmodule
`default_nettype wire

[rtl/led_matrix_cursor_scan_unit.sv]
// Top level of the LED matrix cursor scan unit.
//
// The slave channel takes one word per item: s_tuser selects the action
// (0 checks the buttons, 1 scans the frame), s_tdata carries the first
// sample in bits 3:0 and the confirming sample in bits 7:4.
// A scan word yields eight words on the master channel, top row first,
// with m_tlast on the eighth. A button word yields nothing; a confirmed
// press moves the cursor one step within the edges and sets its pixel.
// A short control program steps the datapath one step per cycle, but it
// waits at the fetch step for a slave word and at an emit step for room
// in the output register. A scan runs one fetch, one dispatch and one
// emit step per row; the first emit step loads the first row onto m_tvalid.
// A button word runs a fetch and a dispatch, two steps for each button
// checked without a press, and three steps for a pressed button: its
// check, the cursor move and the pixel write.
// The rows leave through one output register; while the receiver holds
// m_tready low on any row but the last, the program waits on the next row
// and s_tready stays low.
// Reset clears the cursor to the top left, the frame to a single lit
// pixel under it and all button levels to released.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_cursor_scan_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [lmcs_pkg::S_TDATA_W-1:0]      s_tdata,  // first_sample, confirm_sample
	input  wire                                 s_tuser,  // action
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [lmcs_pkg::M_TDATA_W-1:0]      m_tdata,  // row_index, row_select, column_bits
	output logic                                m_tlast
);

	lmcs_pkg::ctrl_t   ctrl;
	lmcs_pkg::status_t status;

	lmcs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	lmcs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.status   (status),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

[rtl/lmcs_chk.sv]
// Port-level checker for the LED matrix cursor scan unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
module lmcs_chk (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tvalid,
	input wire                             s_tready,
	input wire [lmcs_pkg::S_TDATA_W-1:0]   s_tdata,
	input wire                             s_tuser,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [lmcs_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire                             m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled output word changed.");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:3] == (8'd1 << m_tdata[2:0]))
		else $error("Row select does not match row index.");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2:0] == 3'd7)
		else $error("Last flag on a row other than the bottom row.");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1)
		else $error("Rows of a frame are not back to back in order.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("Input accepted in the middle of a frame.");

endmodule

bind led_matrix_cursor_scan_unit lmcs_chk u_chk (.*);
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the LED matrix cursor scan unit with a frame buffer predictor.
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [3:0] ALL_RELEASED = 4'hF;
	localparam logic ACT_BUTTONS = 1'b0;
	localparam logic ACT_SCAN    = 1'b1;

	typedef struct packed {
		logic [2:0] row_index;
		logic [7:0] row_select;
		logic [7:0] column_bits;
		logic       last_row;
	} row_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	logic [7:0] frame_img [lmcs_pkg::MATRIX_SIZE];
	logic [2:0] cur_row;
	logic [2:0] cur_col;
	logic [3:0] btn_level;
	row_word_t  row_words_q [$];

	bit tx_gaps_on = 1'b1;
	bit rx_stalls_on = 1'b1;
	int error_count = 0;
	int items_sent = 0;
	int scans_sent = 0;
	int moves_seen = 0;
	int words_checked = 0;
	int cycle_count = 0;

	led_matrix_cursor_scan_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("Mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
		error_count++;
	endtask

	function automatic void reset_frame_model();
		foreach (frame_img[i])
			frame_img[i] = '0;
		frame_img[0] = 8'h80;
		cur_row = '0;
		cur_col = 3'd7;
		btn_level = ALL_RELEASED;
	endfunction

	// Returns 1 when the button has a confirmed press; a confirmed change updates the level.
	function automatic bit debounce_button(input int b, input logic [3:0] first,
			input logic [3:0] confirm);
		if (first[b] != btn_level[b] && confirm[b] != btn_level[b]) begin
			btn_level[b] = confirm[b];
			return !confirm[b];
		end
		return 1'b0;
	endfunction

	function automatic void predict_item(input logic action, input logic [3:0] first,
			input logic [3:0] confirm);
		row_word_t w;
		if (action == ACT_SCAN) begin
			for (int i = 0; i < lmcs_pkg::MATRIX_SIZE; i++) begin
				w.row_index = i[2:0];
				w.row_select = 8'h01 << i;
				w.column_bits = frame_img[i];
				w.last_row = (i == lmcs_pkg::EDGE);
				row_words_q.push_back(w);
			end
			return;
		end
		if (debounce_button(lmcs_pkg::BTN_LEFT, first, confirm)) begin
			if (cur_col < lmcs_pkg::EDGE) cur_col++;
		end else if (debounce_button(lmcs_pkg::BTN_UP, first, confirm)) begin
			if (cur_row > 0) cur_row--;
		end else if (debounce_button(lmcs_pkg::BTN_DOWN, first, confirm)) begin
			if (cur_row < lmcs_pkg::EDGE) cur_row++;
		end else if (debounce_button(lmcs_pkg::BTN_RIGHT, first, confirm)) begin
			if (cur_col > 0) cur_col--;
		end else begin
			return;
		end
		moves_seen++;
		frame_img[cur_row] = frame_img[cur_row] | (8'h01 << cur_col);
	endfunction

	task automatic send_item(input logic action, input logic [3:0] first,
			input logic [3:0] confirm);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= {confirm, first};
		do @(posedge clk); while (!s_tready);
		predict_item(action, first, confirm);
		items_sent++;
		if (action == ACT_SCAN) scans_sent++;
	endtask

	task automatic press_and_release(input logic [3:0] pressed);
		if (btn_level != ALL_RELEASED)
			send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		send_item(ACT_BUTTONS, pressed, pressed);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
	endtask

	task automatic random_item();
		logic [3:0] pressed;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			send_item(ACT_SCAN, 4'($urandom), 4'($urandom));
		end else if (pick < 7) begin
			if ($urandom_range(0, 3) == 0)
				pressed = ~4'($urandom_range(1, 15));
			else
				pressed = ~(4'b0001 << $urandom_range(0, 3));
			press_and_release(pressed);
		end else if (pick < 9) begin
			send_item(ACT_BUTTONS, 4'($urandom), btn_level);
		end else begin
			send_item(ACT_BUTTONS, 4'($urandom), 4'($urandom));
		end
	endtask

	initial begin
		@(posedge clk);
		forever begin
			if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : row_check
		row_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (row_words_q.size() == 0) begin
				report_mismatch("unexpected row word", m_tdata, 0);
			end else begin
				want = row_words_q.pop_front();
				words_checked++;
				if (m_tdata[2:0] != want.row_index)
					report_mismatch("row_index", m_tdata[2:0], want.row_index);
				if (m_tdata[10:3] != want.row_select)
					report_mismatch("row_select", m_tdata[10:3], want.row_select);
				if (m_tdata[18:11] != want.column_bits)
					report_mismatch("column_bits", m_tdata[18:11], want.column_bits);
				if (m_tdata[23:19] !== 5'b0)
					report_mismatch("tdata padding", m_tdata[23:19], 0);
				if (m_tlast != want.last_row)
					report_mismatch("last_row", m_tlast, want.last_row);
			end
		end
	end

	task automatic test_directed();
		send_item(ACT_SCAN, 4'h0, 4'h0);
		send_item(ACT_BUTTONS, 4'b1101, 4'b1101);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		send_item(ACT_BUTTONS, 4'b1110, 4'b1110);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		send_item(ACT_BUTTONS, 4'b1011, 4'b1011);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		send_item(ACT_BUTTONS, 4'b0111, 4'b0111);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		// A bounce that is not confirmed, then a change seen only by the late sample.
		send_item(ACT_BUTTONS, 4'h0, ALL_RELEASED);
		send_item(ACT_BUTTONS, ALL_RELEASED, 4'h0);
		// All buttons at once: left wins, then up is the next one to be taken.
		send_item(ACT_BUTTONS, 4'h0, 4'h0);
		send_item(ACT_BUTTONS, 4'h0, 4'h0);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		// A confirmed release of left lets the right press in the same word through.
		send_item(ACT_BUTTONS, 4'b1110, 4'b1110);
		send_item(ACT_BUTTONS, 4'b0111, 4'b0111);
		send_item(ACT_BUTTONS, ALL_RELEASED, ALL_RELEASED);
		send_item(ACT_SCAN, ALL_RELEASED, ALL_RELEASED);
	endtask

	task automatic test_random_walk();
		int burst;
		while (items_sent < 310) begin
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_stalls_on = $urandom_range(0, 3) != 0;
			burst = $urandom_range(10, 40);
			repeat (burst) random_item();
		end
	endtask

	task automatic test_no_idle_tail();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		repeat (25) random_item();
		send_item(ACT_SCAN, 4'h0, 4'h0);
	endtask

	initial begin
		reset_frame_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_walk();
		test_no_idle_tail();
		s_tvalid <= 1'b0;
		wait (row_words_q.size() == 0);
		repeat (20) @(posedge clk);
		if (row_words_q.size() != 0)
			report_mismatch("row words never seen", 0, row_words_q.size());
		$display("Sent %0d words, %0d of them frame scans, with %0d cursor moves.",
			items_sent, scans_sent, moves_seen);
		$display("Checked %0d row words; final cursor at row %0d, column %0d.",
			words_checked, cur_row, cur_col);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
